FILE: src/crc8sd_pkg.sv
package crc8sd_pkg;

  // Default write limit in bytes
  localparam int unsigned MAX_WRITE_BYTES_DEF = 256;

  // Result queue depth (room for two results per request plus slack)
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  localparam logic [7:0] CRC_POLY    = 8'h31;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_TYPE    = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CRC     = 3'd6
  } phase_t;

  localparam logic [1:0] KIND_TYPE    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [1:0] ST_IN_FRAME = 2'd0;
  localparam logic [1:0] ST_CRC_GOOD = 2'd1;
  localparam logic [1:0] ST_CRC_BAD  = 2'd2;
  localparam logic [1:0] ST_CUT      = 2'd3;

  typedef struct packed {
    logic [7:0] byte_value;
    logic [1:0] kind;
    logic [1:0] status;
    logic       last;
  } res_t;

  // Up to two results per accepted byte, packed from slot a
  typedef struct packed {
    logic a_valid;
    res_t a;
    logic b_valid;
    res_t b;
  } push_t;

  // One CRC-8 byte step, MSB first, no reflection
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: src/crc8sd_parse.sv
module crc8sd_parse #(
  parameter int unsigned MAX_WRITE_BYTES = crc8sd_pkg::MAX_WRITE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [7:0]         in_data_byte,
  input  logic               in_end_of_write,
  output crc8sd_pkg::push_t  push
);
  import crc8sd_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_WRITE_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WRITE_BYTES);

  phase_t           phase_r, phase_nxt;
  logic [7:0]       len_hi_r, len_hi_nxt;
  logic [15:0]      remain_r, remain_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [15:0]      remain_dec;
  res_t             cur_res;
  logic             cur_valid;
  res_t             cut_res;
  logic             cut_valid;

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      len_hi_r <= '0;
      remain_r <= '0;
      crc_r    <= '0;
      cnt_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      len_hi_r <= len_hi_nxt;
      remain_r <= remain_nxt;
      crc_r    <= crc_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign remain_dec = remain_r - 16'd1;

  // Advance the frame phase on each accepted request within the write limit
  always_comb begin
    phase_nxt  = phase_r;
    len_hi_nxt = len_hi_r;
    remain_nxt = remain_r;
    crc_nxt    = crc_r;
    cnt_nxt    = cnt_r;
    cur_valid  = 1'b0;
    cur_res    = '{byte_value: in_data_byte, kind: KIND_TYPE, status: ST_IN_FRAME,
                   last: 1'b0};
    cut_valid  = 1'b0;
    cut_res    = '{byte_value: 8'd0, kind: KIND_END, status: ST_CUT, last: 1'b1};

    if (in_fire) begin
      // Bytes past the write limit are dropped
      if (cnt_r < CNT_MAX) begin
        cnt_nxt = cnt_r + CNT_W'(1);
        case (phase_r)
          PH_HUNT: begin
            if (in_data_byte == SYNC_FIRST) phase_nxt = PH_SYNC2;
          end
          PH_SYNC2: begin
            if (in_data_byte == SYNC_SECOND) begin
              phase_nxt = PH_LEN_HI;
            end else if (in_data_byte != SYNC_FIRST) begin
              phase_nxt = PH_HUNT;
            end
          end
          PH_LEN_HI: begin
            len_hi_nxt = in_data_byte;
            phase_nxt  = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            remain_nxt = {len_hi_r, in_data_byte};
            phase_nxt  = PH_TYPE;
          end
          PH_TYPE: begin
            crc_nxt   = crc8_step(8'd0, in_data_byte);
            cur_valid = 1'b1;
            phase_nxt = (remain_r != 16'd0) ? PH_PAYLOAD : PH_CRC;
          end
          PH_PAYLOAD: begin
            crc_nxt      = crc8_step(crc_r, in_data_byte);
            cur_valid    = 1'b1;
            cur_res.kind = KIND_PAYLOAD;
            remain_nxt   = remain_dec;
            if (remain_dec == 16'd0) phase_nxt = PH_CRC;
          end
          PH_CRC: begin
            cur_valid      = 1'b1;
            cur_res.kind   = KIND_END;
            cur_res.status = (in_data_byte == crc_r) ? ST_CRC_GOOD : ST_CRC_BAD;
            cur_res.last   = 1'b1;
            crc_nxt        = 8'd0;
            phase_nxt      = PH_HUNT;
          end
          default: begin
            phase_nxt = PH_HUNT;
          end
        endcase
      end

      // Close an open frame at write end and restart the hunt
      if (in_end_of_write) begin
        cut_valid = (phase_nxt == PH_LEN_HI) || (phase_nxt == PH_LEN_LO) ||
                    (phase_nxt == PH_TYPE) || (phase_nxt == PH_PAYLOAD) ||
                    (phase_nxt == PH_CRC);
        phase_nxt  = PH_HUNT;
        crc_nxt    = 8'd0;
        remain_nxt = 16'd0;
        cnt_nxt    = '0;
      end
    end
  end

  // Pack results from the first slot
  always_comb begin
    push.a_valid = cur_valid | cut_valid;
    push.a       = cur_valid ? cur_res : cut_res;
    push.b_valid = cur_valid & cut_valid;
    push.b       = cut_res;
  end

endmodule

FILE: src/crc8sd_outq.sv
module crc8sd_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  crc8sd_pkg::push_t  push,
  output logic               space_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output crc8sd_pkg::res_t   out_res
);
  import crc8sd_pkg::*;

  res_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              pop;

  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid & out_ready;
  // Accept a request only with room for two results
  assign space_ok  = (count_r <= QCNT_W'(QDEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.a_valid) + QPTR_W'(push.b_valid);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    count_nxt  = count_r + QCNT_W'(push.a_valid) + QCNT_W'(push.b_valid)
                 - QCNT_W'(pop);
  end

  // Hold queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store results in order
  always_ff @(posedge clk) begin
    if (push.a_valid) mem_r[wr_ptr_r] <= push.a;
    if (push.b_valid) mem_r[wr_ptr_r + QPTR_W'(1)] <= push.b;
  end

endmodule

FILE: src/crc8_sync_frame_deframer_core.sv
// Sync / length / CRC-8 frame deframer.
// Each result is registered into the result queue and offered on out_valid behind earlier results.
// Throughput: one byte per cycle while in_ready is high; the parse step is one phase update and one CRC byte step.
// A write end that cuts a frame short adds a second result; the four-entry result
// queue takes a request only with room for two, so in_ready may drop while it drains.
// Reset (rst_n low, synchronous) returns to hunting for sync and empties the queue.
module crc8_sync_frame_deframer_core #(
  parameter int unsigned MAX_WRITE_BYTES = crc8sd_pkg::MAX_WRITE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_write,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte_value,
  output logic [1:0] out_kind,
  output logic [1:0] out_status,
  output logic       out_last
);
  import crc8sd_pkg::*;

  push_t push;
  res_t  out_res;
  logic  space_ok;
  logic  in_fire;

  assign in_ready = space_ok;
  assign in_fire  = in_valid & space_ok;

  crc8sd_parse #(
    .MAX_WRITE_BYTES (MAX_WRITE_BYTES)
  ) u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_fire         (in_fire),
    .in_data_byte    (in_data_byte),
    .in_end_of_write (in_end_of_write),
    .push            (push)
  );

  crc8sd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_byte_value = out_res.byte_value;
  assign out_kind       = out_res.kind;
  assign out_status     = out_res.status;
  assign out_last       = out_res.last;

endmodule
